@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the serial LCD command framer.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/lcdf_pkg.sv @@
// Package of the serial LCD command framer: payload types, codes, constants.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lcdf_pkg;

	// Request codes
	localparam logic [2:0] FUNC_CMD    = 3'd0;
	localparam logic [2:0] FUNC_DATA   = 3'd1;
	localparam logic [2:0] FUNC_STRING = 3'd2;
	localparam logic [2:0] FUNC_CURSOR = 3'd3;
	localparam logic [2:0] FUNC_DEC8   = 3'd4;
	localparam logic [2:0] FUNC_DEC16  = 3'd5;

	localparam int LINE_LEN_DEF   = 20;
	localparam int CELL_COUNT_DEF = 80;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [7:0] SYNC_BYTE   = 8'h1F;
	localparam logic [7:0] RS_BIT      = 8'h40;
	localparam logic [7:0] CURSOR_BASE = 8'h80;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;

	// value / 1000 == (value * RECIP_1000) >> RECIP_SHIFT for any 16-bit value
	localparam logic [16:0] RECIP_1000  = 17'd67109;
	localparam int          RECIP_SHIFT = 26;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] value;
		logic        string_start;
	} lcdf_req_t;

	typedef struct packed {
		logic [23:0] frame;
		logic        last;
	} lcdf_res_t;

	// Classified request as it waits between front and back
	typedef struct packed {
		logic        dec;
		logic        word;
		logic        two;
		logic        data0;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [15:0] value;
	} lcdf_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lcdf_qstat_t;

	function automatic logic [23:0] make_frame(input logic [7:0] b, input logic data);
		make_frame = {4'h0, b[7:4], 4'h0, b[3:0], SYNC_BYTE | (data ? RS_BIT : 8'h00)};
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcdf_queue.sv @@
// Short job queue between the front and back of the serial LCD command framer.
// Depends on lcdf_pkg for the job and status types.
`timescale 1ns / 1ps
`default_nettype none

module lcdf_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  lcdf_pkg::lcdf_job_t    wr_job,
	input  logic                   rd,
	output lcdf_pkg::lcdf_job_t    head,
	output lcdf_pkg::lcdf_qstat_t  stat
);
	import lcdf_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	lcdf_job_t       mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		next_ptr = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr && !rd) count_q <= count_q + 1'b1;
			else if (rd && !wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_job;
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CntW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ hw/rtl/lcdf_front.sv @@
// Front of the serial LCD command framer: accepts requests, keeps the string
// character count, works out cursor commands and queues jobs. Uses lcdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdf_front #(
	parameter int LINE_LEN   = 20,
	parameter int CELL_COUNT = 80
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lcdf_pkg::lcdf_req_t    request,
	input  logic                   full,
	output logic                   job_wr,
	output lcdf_pkg::lcdf_job_t    job
);
	import lcdf_pkg::*;

	localparam int ModSteps = 255 / CELL_COUNT;

	logic [7:0] char_count_q;
	logic       acc;
	logic [7:0] b;
	logic [7:0] cnt_next;
	logic       jump_hit;
	logic [7:0] cur_pos;
	logic [7:0] cur_p;
	logic [1:0] cur_row;
	logic [7:0] cur_col;
	logic       cur_ok;
	logic [7:0] cur_byte;
	logic       has_frames;

	assign acc = push && !full;
	assign b   = request.value[7:0];

	// Cursor command for a position: fold into the display, then pick the row
	always_comb begin
		cnt_next = (request.string_start ? 8'd0 : char_count_q) + 8'd1;
		jump_hit = (cnt_next == 8'(LINE_LEN)) || (cnt_next == 8'(2 * LINE_LEN))
			|| (cnt_next == 8'(3 * LINE_LEN));
		cur_pos = (request.func == FUNC_CURSOR) ? b : cnt_next;
		cur_p = cur_pos;
		for (int k = 1; k <= ModSteps; k++) begin
			if (cur_pos >= 8'(k * CELL_COUNT)) cur_p = cur_pos - 8'(k * CELL_COUNT);
		end
		cur_ok = (cur_p < 8'(4 * LINE_LEN));
		if (cur_p >= 8'(3 * LINE_LEN)) begin
			cur_row = 2'd3;
			cur_col = cur_p - 8'(3 * LINE_LEN);
		end else if (cur_p >= 8'(2 * LINE_LEN)) begin
			cur_row = 2'd2;
			cur_col = cur_p - 8'(2 * LINE_LEN);
		end else if (cur_p >= 8'(LINE_LEN)) begin
			cur_row = 2'd1;
			cur_col = cur_p - 8'(LINE_LEN);
		end else begin
			cur_row = 2'd0;
			cur_col = cur_p;
		end
		cur_byte = CURSOR_BASE + {1'b0, cur_row, 5'b0} + cur_col;
	end

	// Classify the request into a job
	always_comb begin
		job        = '0;
		has_frames = 1'b0;
		unique case (request.func)
			FUNC_CMD: begin
				has_frames = 1'b1;
				job.byte0  = b;
			end
			FUNC_DATA: begin
				has_frames = 1'b1;
				job.byte0  = b;
				job.data0  = 1'b1;
			end
			FUNC_STRING: begin
				has_frames = (b != 8'd0);
				job.byte0  = b;
				job.data0  = 1'b1;
				job.two    = jump_hit && cur_ok;
				job.byte1  = cur_byte;
			end
			FUNC_CURSOR: begin
				has_frames = cur_ok;
				job.byte0  = cur_byte;
			end
			FUNC_DEC8: begin
				has_frames = 1'b1;
				job.dec    = 1'b1;
				job.value  = {8'h00, b};
			end
			FUNC_DEC16: begin
				has_frames = 1'b1;
				job.dec    = 1'b1;
				job.word   = 1'b1;
				job.value  = request.value;
			end
			default: has_frames = 1'b0;
		endcase
	end

	assign job_wr = acc && has_frames;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
		end else if (acc && request.func == FUNC_STRING) begin
			char_count_q <= (b == 8'd0) ? 8'd0 : cnt_next;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lcdf_back.sv @@
// Back of the serial LCD command framer: decimal digit pipeline and the frame
// serializer that holds the result beat. Uses lcdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdf_pkg::lcdf_qstat_t  q_stat,
	input  lcdf_pkg::lcdf_job_t    q_head,
	output logic                   q_rd,
	output lcdf_pkg::lcdf_res_t    result,
	output logic                   empty,
	input  logic                   pop
);
	import lcdf_pkg::*;

	logic      vld_s1, vld_s2, vld_s3, vld_s4;
	lcdf_job_t job_s1, job_s2, job_s3, job_s4;
	logic [6:0] q_s2, q_s3, q_s4;
	logic [9:0] r_s3;
	logic [3:0] h_s4;
	logic [6:0] rem_s4;

	logic        ser_valid_q;
	logic [2:0]  ser_cnt_q;
	logic [3:0][7:0] ser_byte_q;
	logic [3:0]  ser_data_q;

	logic        adv;
	logic        ser_load;
	logic        ser_take;
	logic [32:0] prod;
	logic [9:0]  r_calc;
	logic [3:0]  h_calc;
	logic [9:0]  rem_calc;
	logic [3:0]  tens;
	logic [6:0]  units_w;
	logic [2:0]  ld_cnt;
	logic [3:0][7:0] ld_byte;
	logic [3:0]  ld_data;

	assign ser_take = ser_valid_q && pop;
	assign ser_load = vld_s4 && (!ser_valid_q || (ser_take && ser_cnt_q == 3'd1));
	assign adv      = !vld_s4 || ser_load;
	assign q_rd     = adv && !q_stat.empty;

	// Quotient by 1000 through the reciprocal, then the remainder, then digits
	always_comb begin
		prod   = {17'b0, job_s1.value} * {16'b0, RECIP_1000};
		r_calc = 10'(job_s2.value - 16'({9'b0, q_s2} * 16'd1000));
		h_calc   = '0;
		rem_calc = r_s3;
		for (int k = 1; k <= 9; k++) begin
			if (r_s3 >= 10'(k * 100)) begin
				h_calc   = 4'(k);
				rem_calc = r_s3 - 10'(k * 100);
			end
		end
		tens    = '0;
		units_w = rem_s4;
		for (int k = 1; k <= 9; k++) begin
			if (rem_s4 >= 7'(k * 10)) begin
				tens    = 4'(k);
				units_w = rem_s4 - 7'(k * 10);
			end
		end
	end

	// Frame list for the serializer
	always_comb begin
		if (job_s4.dec) begin
			ld_data = 4'b1111;
			if (job_s4.word) begin
				ld_cnt  = 3'd4;
				ld_byte = {ASCII_ZERO + {4'h0, units_w[3:0]}, ASCII_ZERO + {4'h0, tens},
					ASCII_ZERO + {4'h0, h_s4}, ASCII_ZERO + {1'b0, q_s4}};
			end else begin
				ld_cnt  = 3'd3;
				ld_byte = {8'h00, ASCII_ZERO + {4'h0, units_w[3:0]},
					ASCII_ZERO + {4'h0, tens}, ASCII_ZERO + {4'h0, h_s4}};
			end
		end else begin
			ld_cnt  = job_s4.two ? 3'd2 : 3'd1;
			ld_byte = {16'h0000, job_s4.byte1, job_s4.byte0};
			ld_data = {3'b000, job_s4.data0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			ser_valid_q <= 1'b0;
			ser_cnt_q   <= '0;
		end else begin
			if (adv) begin
				vld_s1 <= !q_stat.empty;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
			end
			if (ser_load) begin
				ser_valid_q <= 1'b1;
				ser_cnt_q   <= ld_cnt;
			end else if (ser_take) begin
				if (ser_cnt_q == 3'd1) ser_valid_q <= 1'b0;
				ser_cnt_q <= ser_cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1 <= q_head;
			job_s2 <= job_s1;
			q_s2   <= prod[RECIP_SHIFT +: 7];
			job_s3 <= job_s2;
			q_s3   <= q_s2;
			r_s3   <= r_calc;
			job_s4 <= job_s3;
			q_s4   <= q_s3;
			h_s4   <= h_calc;
			rem_s4 <= rem_calc[6:0];
		end
		if (ser_load) begin
			ser_byte_q <= ld_byte;
			ser_data_q <= ld_data;
		end else if (ser_take) begin
			ser_byte_q <= {8'h00, ser_byte_q[3:1]};
			ser_data_q <= {1'b0, ser_data_q[3:1]};
		end
	end

	assign result.frame = make_frame(ser_byte_q[0], ser_data_q[0]);
	assign result.last  = (ser_cnt_q == 3'd1);
	assign empty        = !ser_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/serial_lcd_command_framer_core.sv @@
// Channel   Handshake        Payload                 Beat
// request   push / full      lcdf_req_t (20 bits)    one LCD request
// result    empty / pop      lcdf_res_t (25 bits)    one 24-bit serial frame + last
//
// The front is combinational: an accepted request goes through the job queue
// and the digit pipeline to the frame serializer, which sets the rate: one
// frame per cycle while pop stays high. A request makes 0 to 4 frames.
// Requests that make no frame (string end, cursor off the display, unused
// codes) queue no job; a string end clears the count.
// full rises when the four-entry job queue fills; the digit pipeline holds
// while the serializer is busy. Reset clears the queue, pipeline and count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module serial_lcd_command_framer_core #(
	parameter int LINE_LEN   = lcdf_pkg::LINE_LEN_DEF,
	parameter int CELL_COUNT = lcdf_pkg::CELL_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  lcdf_pkg::lcdf_req_t  request,
	output logic                 empty,
	input  logic                 pop,
	output lcdf_pkg::lcdf_res_t  result
);
	import lcdf_pkg::*;

	// Front to queue
	logic        q_push;
	lcdf_job_t   q_job;
	// Queue to back
	lcdf_job_t   q_head;
	lcdf_qstat_t q_stat;
	logic        q_pop;

	// Classify requests and hold the string count
	lcdf_front #(
		.LINE_LEN  (LINE_LEN),
		.CELL_COUNT(CELL_COUNT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.request(request),
		.full   (q_stat.full),
		.job_wr (q_push),
		.job    (q_job)
	);

	// Decouple the front from the serializer
	lcdf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wr_job(q_job),
		.rd    (q_pop),
		.head  (q_head),
		.stat  (q_stat)
	);

	// Expand jobs into digits and frames
	lcdf_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_head(q_head),
		.q_rd  (q_pop),
		.result(result),
		.empty (empty),
		.pop   (pop)
	);

	assign full = q_stat.full;

	// Never write a full queue, never read an empty one
	`CHK_IMPL(a_push_room, clk, arst_n, q_push, !q_stat.full)
	`CHK_IMPL(a_pop_data, clk, arst_n, q_pop, !q_stat.empty)
	// Hold a result after taking any beat that is not the last of its request
	`CHK_NEXT(a_frames_follow, clk, arst_n, !empty && pop && !result.last, !empty)

endmodule

`default_nettype wire
